/* rtl/sddf_pkg.sv */
// ----------------------------------------------------------------------------
// Signed decimal digit formatter package
// State encoding, ASCII codes and divide-by-ten constants for the formatter.
// ----------------------------------------------------------------------------
package sddf_pkg;

    // Default number of decimal digits after the sign
    localparam int DIGIT_COUNT_DEFAULT = 9;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT_SIGN,
        ST_EMIT_DIGIT
    } sddf_state_t;

    // ASCII codes
    localparam logic [6:0] ASCII_PLUS  = 7'd43;
    localparam logic [6:0] ASCII_MINUS = 7'd45;
    localparam logic [6:0] ASCII_ZERO  = 7'd48;

    // floor(x / 10) == (x * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit x
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

endpackage

/* rtl/signed_decimal_digit_formatter.sv */
// ----------------------------------------------------------------------------
// Signed decimal digit formatter
// Formats a 32-bit word as a sign character and DIGIT_COUNT decimal digits.
// ----------------------------------------------------------------------------
// Usage
//   Input channel : in_valid / in_stall / value. An item is taken when
//                   in_valid is high and in_stall is low. Bit 31 of value is
//                   the sign; a negative word is negated to its magnitude.
//   Output channel: out_valid / out_stall / character / last. Each item
//                   yields 1 + DIGIT_COUNT characters: '+' or '-', then the
//                   digits most significant first with leading zeros. last
//                   marks the final character. Magnitudes of 10^DIGIT_COUNT
//                   or more keep only their low DIGIT_COUNT digits.
//   Sequence      : the item is accepted, then divided on the shared
//                   multiply-by-reciprocal divider (one digit per cycle), then
//                   emitted from the output register one character per cycle
//                   while out_stall is low.
//   Stalls        : out_stall holds the output register and, in the emit
//                   states, the sequencer; in_stall is high from acceptance
//                   to the last character being loaded. A new item may
//                   enter while the last character still waits to be taken.
//   Reset         : rst_n clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module signed_decimal_digit_formatter #(
    parameter int DIGIT_COUNT = sddf_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  character,
    output logic        last
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

    sddf_pkg::sddf_state_t state_reg, state_next;

    logic [IDX_W-1:0] count_reg, count_next;
    logic [31:0]      quot_reg, quot_next;
    logic             neg_reg, neg_next;
    logic [3:0]       digit_reg [DIGIT_COUNT];

    logic             out_valid_reg, out_valid_next;
    logic [6:0]       char_reg, char_next;
    logic             last_reg, last_next;

    logic             in_take;
    logic             out_load;
    logic             digit_we;

    // Shared divide-by-ten unit: reciprocal multiply, then remainder by shift-add
    logic [63:0]      prod;
    logic [31:0]      quot_div;
    logic [31:0]      quot_x10;
    logic [31:0]      rem_full;
    logic [3:0]       rem_digit;

    assign prod      = 64'(quot_reg) * 64'(sddf_pkg::DIV10_RECIP);
    assign quot_div  = 32'(prod[63:sddf_pkg::DIV10_SHIFT]);
    assign quot_x10  = {quot_div[28:0], 3'b000} + {quot_div[30:0], 1'b0};
    assign rem_full  = quot_reg - quot_x10;
    assign rem_digit = rem_full[3:0];

    // Handshakes
    assign in_stall = (state_reg != sddf_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    // Output register is free when empty or being drained this cycle
    assign out_load = !out_valid_reg || !out_stall;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sddf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = sddf_pkg::ST_DIVIDE;
                end
            end
            sddf_pkg::ST_DIVIDE:
            begin
                if (count_reg == IDX_LAST)
                begin
                    state_next = sddf_pkg::ST_EMIT_SIGN;
                end
            end
            sddf_pkg::ST_EMIT_SIGN:
            begin
                if (out_load)
                begin
                    state_next = sddf_pkg::ST_EMIT_DIGIT;
                end
            end
            sddf_pkg::ST_EMIT_DIGIT:
            begin
                if (out_load && (count_reg == '0))
                begin
                    state_next = sddf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sddf_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic
    always_comb
    begin
        count_next     = count_reg;
        quot_next      = quot_reg;
        neg_next       = neg_reg;
        digit_we       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            sddf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    // Latch sign and magnitude; 0x80000000 negates to itself
                    neg_next   = value[31];
                    quot_next  = value[31] ? (32'd0 - value) : value;
                    count_next = '0;
                end
            end
            sddf_pkg::ST_DIVIDE:
            begin
                // One digit per cycle, least significant first
                digit_we  = 1'b1;
                quot_next = quot_div;
                if (count_reg != IDX_LAST)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            sddf_pkg::ST_EMIT_SIGN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = neg_reg ? sddf_pkg::ASCII_MINUS : sddf_pkg::ASCII_PLUS;
                    last_next      = 1'b0;
                end
            end
            sddf_pkg::ST_EMIT_DIGIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sddf_pkg::ASCII_ZERO + {3'b000, digit_reg[count_reg]};
                    last_next      = (count_reg == '0);
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sddf_pkg::ST_IDLE;
            count_reg     <= '0;
            quot_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            quot_reg      <= quot_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        if (digit_we)
        begin
            digit_reg[count_reg] <= rem_digit;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_take_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == sddf_pkg::ST_DIVIDE) && (count_reg == '0))
        else $error("accepted item did not start the divide sequence");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sddf_pkg::ST_DIVIDE) && (count_reg == IDX_LAST)
        |=> state_reg == sddf_pkg::ST_EMIT_SIGN)
        else $error("divide phase overran its digit count");

    a_sign_char: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sddf_pkg::ST_EMIT_SIGN) && out_load
        |=> out_valid_reg && !last_reg
            && ((char_reg == sddf_pkg::ASCII_PLUS) || (char_reg == sddf_pkg::ASCII_MINUS)))
        else $error("first character of a run is not a sign");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> state_reg != sddf_pkg::ST_EMIT_DIGIT)
        else $error("last mark shown while digits remain");

endmodule
